// ===== hdl/fat_cluster_table_engine_macros.svh =====
// assertion macros for the cluster table engine
`ifndef FAT_CLUSTER_TABLE_ENGINE_MACROS_SVH
`define FAT_CLUSTER_TABLE_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS
// condition must never hold while out of reset
`define FCT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
// antecedent implies consequent in the same cycle
`define FCT_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// antecedent implies consequent in the next cycle
`define FCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FCT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`define FCT_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define FCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hdl/fct_pkg.sv =====
// constants and helpers for the cluster table engine
package fct_pkg;

  // table geometry
  localparam int CLUSTER_ENTRIES = 16384;
  localparam int IDX_W           = $clog2(CLUSTER_ENTRIES);
  localparam int LINK_W          = 16;
  localparam int CFG_W           = 14;
  localparam int WALK_LIMIT      = (CLUSTER_ENTRIES > 65535) ? 65535 : CLUSTER_ENTRIES;

  // link codes
  localparam logic [LINK_W-1:0] END_MARK  = 16'hFFFF;
  localparam logic [LINK_W-1:0] FREE_MARK = 16'h0000;

  // config reset
  localparam logic [CFG_W-1:0] LAST_CLUSTER_RESET = 14'd16383;

  // request types
  localparam logic [1:0] REQ_FIND  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_FREE  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BROKEN = 2'd2;
  localparam logic [1:0] ST_BAD    = 2'd3;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LINK_W-1:0] link_t;

  // index lies inside the table
  function automatic logic cfg_idx_ok(input logic [CFG_W-1:0] idx);
    return int'(idx) < CLUSTER_ENTRIES;
  endfunction

  // link value names a cluster inside the table
  function automatic logic link_in_table(input link_t lnk);
    return int'(lnk) < CLUSTER_ENTRIES;
  endfunction

  // search bound clamped to the table
  function automatic idx_t clamp_top(input logic [CFG_W-1:0] last);
    idx_t top;
    top = IDX_W'(CLUSTER_ENTRIES - 1);
    if (int'(last) <= CLUSTER_ENTRIES - 1) begin
      top = IDX_W'(last);
    end
    return top;
  endfunction

endpackage

// ===== hdl/fat_cluster_table_engine.sv =====
// cluster link table engine: find free, write, read and free-chain requests
//
// After reset the table RAM is cleared one entry per cycle, during which
// in_ready stays low (cfg writes are still taken). A write request passes
// through the response state, a read request through the read and response
// states, before its result is loaded into the output register. A find-free
// request reads entries from cluster 1 up to the search bound, and a free-chain
// request reads each chain entry in turn: the table has one read and one write
// port, and walks issue one read per cycle. A request with a bad index, or a
// find with a zero bound, goes straight to the response state. A new request
// is accepted at the edge after its predecessor's result is loaded, even while
// that result still waits in the output register; the engine stalls only while
// a finished result cannot be loaded because the output register is still full.
`include "fat_cluster_table_engine_macros.svh"

module fat_cluster_table_engine
  import fct_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // configuration
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  // request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_req_type,
  input  logic [CFG_W-1:0]    in_cluster_index,
  input  logic [LINK_W-1:0]   in_entry_value,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic [LINK_W-1:0]   out_result_value,
  output logic [1:0]          out_status
);

  // engine states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FIND  = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_FREE  = 3'd4;
  localparam logic [2:0] S_RESP  = 3'd5;

  // table memory
  link_t link_mem [CLUSTER_ENTRIES];

  logic               mem_we;
  idx_t               mem_waddr;
  link_t              mem_wdata;
  logic               mem_re;
  idx_t               mem_raddr;
  link_t              mem_rdata_r;

  // forwarding of a same-cycle write over a read
  logic               fwd_hit_r;
  link_t              fwd_data_r;
  link_t              rd_link;

  // control and walk registers
  logic [2:0]         state_r, state_nxt;
  logic [CFG_W-1:0]   last_cluster_r;
  idx_t               clr_addr_r, clr_addr_nxt;
  idx_t               scan_r, scan_nxt;
  idx_t               top_r, top_nxt;
  logic [LINK_W-1:0]  count_r, count_nxt;
  logic [LINK_W-1:0]  res_value_r, res_value_nxt;
  logic [1:0]         res_status_r, res_status_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [LINK_W-1:0]  out_value_r;
  logic [1:0]         out_status_r;
  logic               out_load;

  logic               in_fire;
  idx_t               in_idx;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_idx    = IDX_W'(in_cluster_index);
  assign out_valid = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_status       = out_status_r;

  assign rd_link  = fwd_hit_r ? fwd_data_r : mem_rdata_r;
  assign out_load = (state_r == S_RESP) && (!out_valid_r || out_ready);

  // ram with one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= link_mem[mem_raddr];
    end
  end

  // next state, ram access and walk logic
  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    scan_nxt       = scan_r;
    top_nxt        = top_r;
    count_nxt      = count_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    mem_we         = 1'b0;
    mem_waddr      = clr_addr_r;
    mem_wdata      = FREE_MARK;
    mem_re         = 1'b0;
    mem_raddr      = scan_r;

    unique case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == IDX_W'(CLUSTER_ENTRIES - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          res_value_nxt  = '0;
          res_status_nxt = ST_OK;
          unique case (in_req_type)
            REQ_FIND: begin
              top_nxt = clamp_top(last_cluster_r);
              if (top_nxt == '0) begin
                res_status_nxt = ST_FULL;
                state_nxt      = S_RESP;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = IDX_W'(1);
                scan_nxt  = IDX_W'(1);
                state_nxt = S_FIND;
              end
            end
            REQ_WRITE: begin
              if (cfg_idx_ok(in_cluster_index)) begin
                mem_we    = 1'b1;
                mem_waddr = in_idx;
                mem_wdata = in_entry_value;
              end else begin
                res_status_nxt = ST_BAD;
              end
              state_nxt = S_RESP;
            end
            REQ_READ: begin
              if (cfg_idx_ok(in_cluster_index)) begin
                mem_re    = 1'b1;
                mem_raddr = in_idx;
                state_nxt = S_RD;
              end else begin
                res_status_nxt = ST_BAD;
                state_nxt      = S_RESP;
              end
            end
            REQ_FREE: begin
              if (in_cluster_index == '0 || !cfg_idx_ok(in_cluster_index)) begin
                res_status_nxt = ST_BAD;
                state_nxt      = S_RESP;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = in_idx;
                scan_nxt  = in_idx;
                count_nxt = '0;
                state_nxt = S_FREE;
              end
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      // one entry checked per cycle, next read issued alongside
      S_FIND: begin
        if (rd_link == FREE_MARK) begin
          res_value_nxt  = LINK_W'(scan_r);
          res_status_nxt = ST_OK;
          state_nxt      = S_RESP;
        end else if (scan_r == top_r) begin
          res_value_nxt  = '0;
          res_status_nxt = ST_FULL;
          state_nxt      = S_RESP;
        end else begin
          scan_nxt  = scan_r + 1'b1;
          mem_re    = 1'b1;
          mem_raddr = scan_nxt;
        end
      end

      S_RD: begin
        res_value_nxt = rd_link;
        state_nxt     = S_RESP;
      end

      // zero the current entry and follow its old link
      S_FREE: begin
        if (count_r >= LINK_W'(WALK_LIMIT) || rd_link == FREE_MARK) begin
          res_value_nxt  = count_r;
          res_status_nxt = ST_BROKEN;
          state_nxt      = S_RESP;
        end else begin
          mem_we        = 1'b1;
          mem_waddr     = scan_r;
          mem_wdata     = FREE_MARK;
          count_nxt     = count_r + 1'b1;
          res_value_nxt = count_nxt;
          if (rd_link == END_MARK) begin
            res_status_nxt = ST_OK;
            state_nxt      = S_RESP;
          end else if (!link_in_table(rd_link)) begin
            res_status_nxt = ST_BAD;
            state_nxt      = S_RESP;
          end else begin
            scan_nxt  = IDX_W'(rd_link);
            mem_re    = 1'b1;
            mem_raddr = scan_nxt;
          end
        end
      end

      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid tracking
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_CLEAR;
      clr_addr_r     <= '0;
      last_cluster_r <= LAST_CLUSTER_RESET;
      out_valid_r    <= 1'b0;
      fwd_hit_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
      fwd_hit_r   <= mem_we && mem_re && (mem_waddr == mem_raddr);
      if (cfg_wr_en) begin
        last_cluster_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    top_r        <= top_nxt;
    count_r      <= count_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    fwd_data_r   <= mem_wdata;
    if (out_load) begin
      out_value_r  <= res_value_r;
      out_status_r <= res_status_r;
    end
  end

  // checks on the engine's own logic
  `FCT_ASSERT_NEVER(a_walk_count_bound, clk, rst_n, count_r > LINK_W'(WALK_LIMIT) && state_r == S_FREE, "free walk count beyond limit")
  `FCT_ASSERT_NEVER(a_no_stray_write, clk, rst_n, mem_we && (state_r == S_FIND || state_r == S_RD || state_r == S_RESP), "table written outside clear, write or free")
  `FCT_ASSERT_NEVER(a_scan_in_bound, clk, rst_n, state_r == S_FIND && (scan_r > top_r || scan_r == '0), "find scan outside search bound")
  `FCT_ASSERT_IMPLIES(a_fwd_only_in_free, clk, rst_n, fwd_hit_r, state_r == S_FREE, "forwarded data outside a free walk")

endmodule

// ===== sim/fct_result_checker.sv =====
// result checker for the cluster table engine: predicts and compares every result
module fct_result_checker
  import fct_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [CFG_W-1:0]  in_cluster_index,
  input  logic [LINK_W-1:0] in_entry_value,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [LINK_W-1:0] out_result_value,
  input  logic [1:0]        out_status,
  output int unsigned       error_count,
  output int unsigned       results_owed
);

  typedef struct packed {
    link_t      value;
    logic [1:0] status;
  } table_result_t;

  // shadow copy of the link table and the search bound
  link_t            cluster_links [CLUSTER_ENTRIES];
  logic [CFG_W-1:0] search_bound;
  table_result_t    owed_results [$];

  // first free entry from cluster 1 up to the search bound
  function automatic table_result_t find_first_free();
    table_result_t r;
    int top;
    top = int'(search_bound);
    if (top > CLUSTER_ENTRIES - 1) begin
      top = CLUSTER_ENTRIES - 1;
    end
    r.value  = '0;
    r.status = ST_FULL;
    for (int i = 1; i <= top; i++) begin
      if (cluster_links[i] == FREE_MARK) begin
        r.value  = LINK_W'(i);
        r.status = ST_OK;
        return r;
      end
    end
    return r;
  endfunction

  // zero a chain entry by entry, following the old links
  function automatic table_result_t free_chain_from(input int start);
    table_result_t r;
    int cur;
    int count;
    link_t nxt;
    r.value  = '0;
    r.status = ST_BAD;
    if (start == 0 || start >= CLUSTER_ENTRIES) begin
      return r;
    end
    cur   = start;
    count = 0;
    forever begin
      if (count >= WALK_LIMIT) begin
        r.status = ST_BROKEN;
        break;
      end
      nxt = cluster_links[cur];
      // already free: chain is broken here
      if (nxt == FREE_MARK) begin
        r.status = ST_BROKEN;
        break;
      end
      cluster_links[cur] = FREE_MARK;
      count++;
      if (nxt == END_MARK) begin
        r.status = ST_OK;
        break;
      end
      // link points past the table
      if (int'(nxt) >= CLUSTER_ENTRIES) begin
        r.status = ST_BAD;
        break;
      end
      cur = int'(nxt);
    end
    r.value = LINK_W'(count);
    return r;
  endfunction

  // expected result of one request, updating the shadow table
  function automatic table_result_t predict_request(input logic [1:0] req,
                                                    input logic [CFG_W-1:0] idx,
                                                    input link_t val);
    table_result_t r;
    r.value  = '0;
    r.status = ST_OK;
    case (req)
      REQ_FIND: begin
        r = find_first_free();
      end
      REQ_WRITE: begin
        if (int'(idx) >= CLUSTER_ENTRIES) begin
          r.status = ST_BAD;
        end else begin
          cluster_links[int'(idx)] = val;
        end
      end
      REQ_READ: begin
        if (int'(idx) >= CLUSTER_ENTRIES) begin
          r.status = ST_BAD;
        end else begin
          r.value = cluster_links[int'(idx)];
        end
      end
      default: begin
        r = free_chain_from(int'(idx));
      end
    endcase
    return r;
  endfunction

  // watch config, requests and results at each rising edge
  always @(posedge clk) begin
    table_result_t want;
    if (!rst_n) begin
      foreach (cluster_links[i]) cluster_links[i] = FREE_MARK;
      search_bound = LAST_CLUSTER_RESET;
      owed_results.delete();
      error_count = 0;
    end else begin
      if (cfg_wr_en) begin
        search_bound = cfg_wr_data;
      end
      // compare the result against the oldest prediction
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $display("%0t: unexpected result value %h status %0d", $time,
                   out_result_value, out_status);
          error_count++;
        end else begin
          want = owed_results.pop_front();
          if (out_result_value !== want.value) begin
            $display("%0t: result_value expected %h actual %h", $time,
                     want.value, out_result_value);
            error_count++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, out_status);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        owed_results.push_back(predict_request(in_req_type, in_cluster_index,
                                               in_entry_value));
      end
    end
    results_owed = owed_results.size();
  end

endmodule

// ===== sim/tb_fat_cluster_table_engine.sv =====
// testbench top for the cluster table engine: stimulus, flow control and verdict
module tb_fat_cluster_table_engine;
  import fct_pkg::*;

  localparam int CYCLE_LIMIT     = 1500000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int WORK_TOP        = 63;
  localparam int SEGMENTS        = 8;
  localparam int SEGMENT_REQS    = 180;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [CFG_W-1:0]  cfg_wr_data;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        in_req_type;
  logic [CFG_W-1:0]  in_cluster_index;
  logic [LINK_W-1:0] in_entry_value;
  logic              out_valid;
  logic              out_ready;
  logic [LINK_W-1:0] out_result_value;
  logic [1:0]        out_status;

  int unsigned error_count;
  int unsigned results_owed;
  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_asks          = 0;
  int unsigned cycle_count        = 0;

  always #6 clk = ~clk;

  fat_cluster_table_engine DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_cluster_index (in_cluster_index),
    .in_entry_value   (in_entry_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_status       (out_status)
  );

  fct_result_checker result_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_cluster_index (in_cluster_index),
    .in_entry_value   (in_entry_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_status       (out_status),
    .error_count      (error_count),
    .results_owed     (results_owed)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stalls, and one long hold-off per request for one
  initial begin
    int unsigned holds_done;
    holds_done = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != holds_done) begin
        holds_done = hold_asks;
        out_ready  = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end
      out_ready = ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // offer one request, with random idle gaps, until it is taken
  task automatic issue_request(input logic [1:0] req, input logic [CFG_W-1:0] idx,
                               input link_t val);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid         = 1'b1;
    in_req_type      = req;
    in_cluster_index = idx;
    in_entry_value   = val;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending and wait for every owed result
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // write the search bound while the engine is idle
  task automatic set_search_bound(input logic [CFG_W-1:0] bound);
    wait_results_drained();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = bound;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin
    int          seg;
    int          sent;
    int          pick;
    int          chain_len;
    int          k;
    int          j;
    bit          dup;
    int unsigned chain_nodes [6];
    link_t       tail;
    link_t       wval;
    logic [CFG_W-1:0] bound;
    logic [CFG_W-1:0] ridx;

    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_valid         = 1'b0;
    in_req_type      = REQ_FIND;
    in_cluster_index = '0;
    in_entry_value   = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed: table edges, reserved cluster, each walk outcome
    issue_request(REQ_READ, '0, '0);
    issue_request(REQ_FIND, '0, '0);
    issue_request(REQ_WRITE, CFG_W'(CLUSTER_ENTRIES - 1), END_MARK);
    issue_request(REQ_READ, CFG_W'(CLUSTER_ENTRIES - 1), '0);
    issue_request(REQ_FREE, CFG_W'(CLUSTER_ENTRIES - 1), '0);
    issue_request(REQ_WRITE, '0, 16'h1234);
    issue_request(REQ_READ, '0, '0);
    issue_request(REQ_FREE, '0, '0);
    issue_request(REQ_FREE, CFG_W'(5), '0);
    // clean chain 1 -> 2 -> 3 -> end
    issue_request(REQ_WRITE, CFG_W'(1), 16'd2);
    issue_request(REQ_WRITE, CFG_W'(2), 16'd3);
    issue_request(REQ_WRITE, CFG_W'(3), END_MARK);
    issue_request(REQ_FIND, '0, '0);
    issue_request(REQ_FREE, CFG_W'(1), '0);
    // chain running into a free entry
    issue_request(REQ_WRITE, CFG_W'(10), 16'd11);
    issue_request(REQ_FREE, CFG_W'(10), '0);
    // chain linking past the table
    issue_request(REQ_WRITE, CFG_W'(20), 16'h4000);
    issue_request(REQ_FREE, CFG_W'(20), '0);
    // zero bound, then a bound of one with its entry taken
    set_search_bound('0);
    issue_request(REQ_FIND, '0, '0);
    set_search_bound(CFG_W'(1));
    issue_request(REQ_WRITE, CFG_W'(1), 16'hFFFE);
    issue_request(REQ_FIND, '0, '0);
    issue_request(REQ_WRITE, CFG_W'(1), FREE_MARK);
    issue_request(REQ_FIND, '0, '0);

    // random segments, each with its own bound and flow control
    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0, 4, 7: bound = LAST_CLUSTER_RESET;
        1:       bound = CFG_W'(5);
        3:       bound = CFG_W'(40);
        5:       bound = CFG_W'(1);
        default: bound = CFG_W'($urandom_range(1, 2 * WORK_TOP));
      endcase
      set_search_bound(bound);
      case (seg % 4)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct    = 56;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 56;
        end
        default: begin
          sender_idle_pct    = 6;
          receiver_stall_pct = 6;
        end
      endcase
      // long receiver hold-off while requests keep coming
      if (seg == 0 || seg == 4) begin
        hold_asks++;
      end
      sent = 0;
      while (sent < SEGMENT_REQS) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          // build a chain of distinct clusters, then usually free it
          chain_len = $urandom_range(1, 6);
          for (k = 0; k < chain_len; k++) begin
            do begin
              chain_nodes[k] = $urandom_range(1, WORK_TOP);
              dup = 1'b0;
              for (j = 0; j < k; j++) begin
                if (chain_nodes[j] == chain_nodes[k]) dup = 1'b1;
              end
            end while (dup);
          end
          case ($urandom_range(9))
            8:       tail = FREE_MARK;
            9:       tail = LINK_W'($urandom_range(CLUSTER_ENTRIES, 16'hFFFE));
            default: tail = END_MARK;
          endcase
          for (k = 0; k < chain_len; k++) begin
            wval = (k == chain_len - 1) ? tail : LINK_W'(chain_nodes[k + 1]);
            issue_request(REQ_WRITE, CFG_W'(chain_nodes[k]), wval);
            sent++;
          end
          if ($urandom_range(3) == 0) begin
            issue_request(REQ_READ, CFG_W'(chain_nodes[$urandom_range(0, chain_len - 1)]),
                          LINK_W'($urandom));
            sent++;
          end
          if ($urandom_range(9) < 7) begin
            issue_request(REQ_FREE, CFG_W'(chain_nodes[0]), LINK_W'($urandom));
            sent++;
          end
        end else if (pick < 60) begin
          issue_request(REQ_FIND, CFG_W'($urandom), LINK_W'($urandom));
          sent++;
        end else if (pick < 75) begin
          ridx = ($urandom_range(3) == 0) ? CFG_W'($urandom_range(0, CLUSTER_ENTRIES - 1))
                                          : CFG_W'($urandom_range(0, WORK_TOP));
          issue_request(REQ_READ, ridx, LINK_W'($urandom));
          sent++;
        end else if (pick < 90) begin
          // noise writes: any value, markers, or a link into the working area
          ridx = ($urandom_range(3) == 0) ? CFG_W'($urandom_range(0, CLUSTER_ENTRIES - 1))
                                          : CFG_W'($urandom_range(0, WORK_TOP));
          case ($urandom_range(3))
            0:       wval = LINK_W'($urandom);
            1:       wval = END_MARK;
            2:       wval = FREE_MARK;
            default: wval = LINK_W'($urandom_range(1, WORK_TOP));
          endcase
          issue_request(REQ_WRITE, ridx, wval);
          sent++;
        end else begin
          case ($urandom_range(9))
            0:       ridx = '0;
            1:       ridx = CFG_W'($urandom_range(0, CLUSTER_ENTRIES - 1));
            default: ridx = CFG_W'($urandom_range(1, WORK_TOP));
          endcase
          issue_request(REQ_FREE, ridx, LINK_W'($urandom));
          sent++;
        end
      end
    end

    wait_results_drained();
    repeat (32) @(negedge clk);
    if (error_count == 0 && results_owed == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
